/* sv/kad_pkg.sv */
// ----------------------------------------------------------------------------
// kad_pkg
// Shared types, key codes and translation tables for the set-1 key decoder.
// ----------------------------------------------------------------------------
package kad_pkg;

  localparam int unsigned ScanW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned ActW    = 3;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned TableLen = 58;

  localparam logic [ScanW-1:0] KEY_RELEASE = 8'h80;
  localparam logic [ScanW-1:0] KEY_ENTER   = 8'h1C;
  localparam logic [ScanW-1:0] KEY_N       = 8'h31;
  localparam logic [ScanW-1:0] KEY_CTRL    = 8'h1D;
  localparam logic [ScanW-1:0] KEY_LSHIFT  = 8'h2A;
  localparam logic [ScanW-1:0] KEY_RSHIFT  = 8'h36;
  localparam logic [ScanW-1:0] KEY_S       = 8'h1F;
  localparam logic [ScanW-1:0] KEY_X       = 8'h2D;
  localparam logic [ScanW-1:0] KEY_J       = 8'h24;
  localparam logic [ScanW-1:0] KEY_UP      = 8'h48;
  localparam logic [ScanW-1:0] KEY_DOWN    = 8'h50;

  localparam logic [CharW-1:0] CC_S = 7'h13;
  localparam logic [CharW-1:0] CC_X = 7'h18;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_CHAR    = 3'd1,
    ACT_UP      = 3'd2,
    ACT_DOWN    = 3'd3,
    ACT_CYCLE   = 3'd4,
    ACT_CONFIRM = 3'd5,
    ACT_SPAWN   = 3'd6
  } act_t;

  // unshifted character for scancodes 0..57, zero where the key has none
  function automatic logic [CharW-1:0] plain_map(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      6'd1:  c = 7'h1b;  6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;  6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;  6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2d;
      6'd13: c = 7'h3d;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h71;
      6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;  6'd20: c = 7'h74;
      6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;  6'd24: c = 7'h6f;
      6'd25: c = 7'h70;  6'd26: c = 7'h5b;  6'd27: c = 7'h5d;  6'd28: c = 7'h0a;
      6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
      6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6a;  6'd37: c = 7'h6b;
      6'd38: c = 7'h6c;  6'd39: c = 7'h3b;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
      6'd43: c = 7'h5c;  6'd44: c = 7'h7a;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
      6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6e;  6'd50: c = 7'h6d;
      6'd51: c = 7'h2c;  6'd52: c = 7'h2e;  6'd53: c = 7'h2f;  6'd55: c = 7'h2a;
      6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  // shifted character for scancodes 0..57
  function automatic logic [CharW-1:0] shift_map(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      6'd1:  c = 7'h1b;  6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;  6'd6:  c = 7'h25;  6'd7:  c = 7'h5e;  6'd8:  c = 7'h26;
      6'd9:  c = 7'h2a;  6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5f;
      6'd13: c = 7'h2b;  6'd14: c = 7'h08;  6'd15: c = 7'h09;  6'd16: c = 7'h51;
      6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;  6'd20: c = 7'h54;
      6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;  6'd24: c = 7'h4f;
      6'd25: c = 7'h50;  6'd26: c = 7'h7b;  6'd27: c = 7'h7d;  6'd28: c = 7'h0a;
      6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
      6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4a;  6'd37: c = 7'h4b;
      6'd38: c = 7'h4c;  6'd39: c = 7'h3a;  6'd40: c = 7'h22;  6'd41: c = 7'h7e;
      6'd43: c = 7'h7c;  6'd44: c = 7'h5a;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
      6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4e;  6'd50: c = 7'h4d;
      6'd51: c = 7'h3c;  6'd52: c = 7'h3e;  6'd53: c = 7'h3f;  6'd55: c = 7'h2a;
      6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* sv/kad_if.sv */
// ----------------------------------------------------------------------------
// kad_in_if / kad_out_if
// Valid/ready channels for scancodes in and key actions out.
// ----------------------------------------------------------------------------
interface kad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;
  logic       switcher_active;

  modport source(output valid, scan_code, switcher_active, input ready);
  modport sink(input valid, scan_code, switcher_active, output ready);
endinterface

interface kad_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] char_code;

  modport source(output valid, action, char_code, input ready);
  modport sink(input valid, action, char_code, output ready);
endinterface

/* sv/scancode_to_key_action_decoder_core.sv */
// ----------------------------------------------------------------------------
// scancode_to_key_action_decoder_core
// Decodes set-1 scancodes into key actions and ASCII characters.
// ----------------------------------------------------------------------------
//   channel  dir  payload                       transaction
//   scan     in   scan_code[7:0], switcher_active   one scancode byte
//   result   out  action[2:0], char_code[6:0]       one action per scancode
//
// One transaction per cycle sustained while the result is not stalled; an
// accepted scan transaction passes through the input register, then the result
// register, and its result is valid once it is in the result register.
// The ctrl and shift flags update when an item moves into the result register.
// rst clears both flags and both valid bits; payload registers are not reset.
// A stalled result holds its register; the input register keeps taking items
// while it is empty or drains in the same cycle.
module scancode_to_key_action_decoder_core
  import kad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  kad_in_if.sink    scan,
  kad_out_if.source result
);

  logic             in_valid;
  logic [ScanW-1:0] in_scan;
  logic             in_sw;

  logic             res_valid;
  act_t             res_act;
  logic [CharW-1:0] res_char;

  logic ctrl_held, ctrl_held_next;
  logic shift_held, shift_held_next;

  act_t             act_next;
  logic [CharW-1:0] char_next;
  logic [CharW-1:0] tbl_char;
  logic [IdxW-1:0]  idx;
  logic             advance;

  assign advance    = in_valid && (!res_valid || result.ready);
  assign scan.ready = !in_valid || advance;

  assign result.valid     = res_valid;
  assign result.action    = res_act;
  assign result.char_code = res_char;

  assign idx      = in_scan[IdxW-1:0];
  assign tbl_char = shift_held ? shift_map(idx) : plain_map(idx);

  always_comb begin
    ctrl_held_next  = ctrl_held;
    shift_held_next = shift_held;
    act_next        = ACT_NONE;
    char_next       = '0;
    if (in_scan == KEY_CTRL) begin
      ctrl_held_next = 1'b1;
    end else if (in_scan == (KEY_CTRL | KEY_RELEASE)) begin
      ctrl_held_next = 1'b0;
    end else if (in_scan inside {KEY_LSHIFT, KEY_RSHIFT}) begin
      shift_held_next = 1'b1;
    end else if (in_scan inside {KEY_LSHIFT | KEY_RELEASE, KEY_RSHIFT | KEY_RELEASE}) begin
      shift_held_next = 1'b0;
    end else if ((in_scan & KEY_RELEASE) == '0) begin
      if (in_scan == KEY_UP) begin
        act_next = ACT_UP;
      end else if (in_scan == KEY_DOWN) begin
        act_next = ACT_DOWN;
      end else if (ctrl_held && in_scan == KEY_J) begin
        act_next = ACT_CYCLE;
      end else if (in_sw) begin
        if (in_scan == KEY_ENTER) begin
          act_next = ACT_CONFIRM;
        end
      end else if (in_scan < ScanW'(TableLen)) begin
        if (ctrl_held) begin
          // only S, X and N do anything while ctrl is down
          if (in_scan == KEY_S) begin
            act_next  = ACT_CHAR;
            char_next = CC_S;
          end else if (in_scan == KEY_X) begin
            act_next  = ACT_CHAR;
            char_next = CC_X;
          end else if (in_scan == KEY_N) begin
            act_next = ACT_SPAWN;
          end
        end else if (tbl_char != '0) begin
          act_next  = ACT_CHAR;
          char_next = tbl_char;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan.ready) begin
      in_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_scan <= scan.scan_code;
      in_sw   <= scan.switcher_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      ctrl_held  <= 1'b0;
      shift_held <= 1'b0;
    end else begin
      if (advance) begin
        res_valid  <= 1'b1;
        ctrl_held  <= ctrl_held_next;
        shift_held <= shift_held_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_act  <= act_next;
      res_char <= char_next;
    end
  end

endmodule

/* tb/kad_key_action_sb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kad_key_action_sb_pkg
// Scoreboard for the set-1 key decoder: predicts the key action of each
// accepted scancode and checks the results in order.
// ----------------------------------------------------------------------------
package kad_key_action_sb_pkg;
  import kad_pkg::*;

  typedef struct packed {
    act_t             action;
    logic [CharW-1:0] char_code;
  } key_action_t;

  // characters of scancodes 0..57, without and with shift
  localparam logic [0:57][6:0] UNSHIFTED_CHARS = {
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
    7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20
  };

  localparam logic [0:57][6:0] SHIFTED_CHARS = {
    7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
    7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
    7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20
  };

  class key_action_scoreboard;
    bit          ctrl_down;
    bit          shift_down;
    key_action_t expected_actions[$];
    int          errors;

    function new();
      ctrl_down  = 1'b0;
      shift_down = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_actions.size();
    endfunction

    // decode one accepted scancode and queue the action it should produce
    function void note_scan(logic [ScanW-1:0] sc, logic sw);
      key_action_t      res;
      logic [CharW-1:0] ch;
      res.action    = ACT_NONE;
      res.char_code = '0;
      if (sc == KEY_CTRL) begin
        ctrl_down = 1'b1;
      end else if (sc == (KEY_CTRL | KEY_RELEASE)) begin
        ctrl_down = 1'b0;
      end else if (sc == KEY_LSHIFT || sc == KEY_RSHIFT) begin
        shift_down = 1'b1;
      end else if (sc == (KEY_LSHIFT | KEY_RELEASE) || sc == (KEY_RSHIFT | KEY_RELEASE)) begin
        shift_down = 1'b0;
      end else if ((sc & KEY_RELEASE) == '0) begin
        if (sc == KEY_UP) begin
          res.action = ACT_UP;
        end else if (sc == KEY_DOWN) begin
          res.action = ACT_DOWN;
        end else if (ctrl_down && sc == KEY_J) begin
          res.action = ACT_CYCLE;
        end else if (sw) begin
          // overlay shown: only enter does something
          if (sc == KEY_ENTER) res.action = ACT_CONFIRM;
        end else if (sc < TableLen) begin
          ch = shift_down ? SHIFTED_CHARS[sc] : UNSHIFTED_CHARS[sc];
          if (ctrl_down) begin
            if (sc == KEY_S) begin
              ch = CC_S;
            end else if (sc == KEY_X) begin
              ch = CC_X;
            end else if (sc == KEY_N) begin
              ch = '0;
              res.action = ACT_SPAWN;
            end else begin
              ch = '0;
            end
          end
          if (ch != '0) begin
            res.action    = ACT_CHAR;
            res.char_code = ch;
          end
        end
      end
      expected_actions.push_back(res);
    endfunction

    function void check_result(logic [ActW-1:0] action, logic [CharW-1:0] char_code);
      key_action_t exp_res;
      if (expected_actions.size() == 0) begin
        $error("unexpected result transaction: action %0d char_code 0x%0h", action, char_code);
        errors++;
        return;
      end
      exp_res = expected_actions.pop_front();
      if (action !== exp_res.action) begin
        $error("action: expected %0d, got %0d", exp_res.action, action);
        errors++;
      end
      if (char_code !== exp_res.char_code) begin
        $error("char_code: expected 0x%0h, got 0x%0h", exp_res.char_code, char_code);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/tb_scancode_to_key_action_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_to_key_action_decoder_core
// Drives directed and random scancodes through the decoder with random gaps
// and output stalls, and checks every key action against a scoreboard.
// ----------------------------------------------------------------------------
module tb_scancode_to_key_action_decoder_core;
  import kad_pkg::*;
  import kad_key_action_sb_pkg::*;

  localparam int RandomScans = 1100;

  logic clk;
  logic rst;
  bit   steady;

  kad_in_if  scan_if();
  kad_out_if result_if();

  key_action_scoreboard sb;

  scancode_to_key_action_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan_if),
    .result (result_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly back to back, sometimes a short gap, rarely a long pause; none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ScanW-1:0] pick_modifier();
    case ($urandom_range(0, 5))
      0: return KEY_CTRL;
      1: return KEY_CTRL | KEY_RELEASE;
      2: return KEY_LSHIFT;
      3: return KEY_LSHIFT | KEY_RELEASE;
      4: return KEY_RSHIFT;
      default: return KEY_RSHIFT | KEY_RELEASE;
    endcase
  endfunction

  function automatic logic [ScanW-1:0] pick_scan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return pick_modifier();
    if (r < 22) return $urandom_range(0, 1) ? KEY_UP : KEY_DOWN;
    if (r < 32) begin
      case ($urandom_range(0, 4))
        0: return KEY_J;
        1: return KEY_S;
        2: return KEY_X;
        3: return KEY_N;
        default: return KEY_ENTER;
      endcase
    end
    if (r < 70) return ScanW'($urandom_range(0, TableLen - 1));
    if (r < 82) return ScanW'($urandom_range(TableLen, 127));
    return ScanW'($urandom_range(128, 255));
  endfunction

  task automatic send_scan(input logic [ScanW-1:0] sc, input logic sw, input bit drain);
    int gap;
    gap = pick_gap();
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      scan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && sb.pending() != 0) @(posedge clk);
    end
    scan_if.valid           <= 1'b1;
    scan_if.scan_code       <= sc;
    scan_if.switcher_active <= sw;
    do @(posedge clk); while (!scan_if.ready);
    sb.note_scan(sc, sw);
  endtask

  task automatic run_directed();
    send_scan(8'h00, 1'b0, 1'b0);
    send_scan(8'hFF, 1'b1, 1'b0);
    send_scan(KEY_UP, 1'b0, 1'b0);
    send_scan(KEY_DOWN, 1'b0, 1'b0);
    send_scan(8'h02, 1'b0, 1'b0);
    send_scan(KEY_LSHIFT, 1'b0, 1'b0);
    send_scan(8'h02, 1'b0, 1'b0);
    send_scan(8'h39, 1'b0, 1'b0);
    send_scan(KEY_LSHIFT | KEY_RELEASE, 1'b0, 1'b0);
    send_scan(KEY_RSHIFT, 1'b0, 1'b0);
    send_scan(8'h10, 1'b0, 1'b0);
    send_scan(KEY_RSHIFT | KEY_RELEASE, 1'b0, 1'b0);
    send_scan(KEY_CTRL, 1'b0, 1'b0);
    send_scan(KEY_J, 1'b0, 1'b0);
    send_scan(KEY_S, 1'b0, 1'b0);
    send_scan(KEY_X, 1'b0, 1'b0);
    send_scan(KEY_N, 1'b0, 1'b0);
    send_scan(8'h10, 1'b0, 1'b0);
    send_scan(KEY_J, 1'b1, 1'b0);
    send_scan(KEY_ENTER, 1'b1, 1'b0);
    send_scan(KEY_CTRL | KEY_RELEASE, 1'b0, 1'b0);
    send_scan(KEY_ENTER, 1'b1, 1'b0);
    send_scan(8'h10, 1'b1, 1'b0);
    send_scan(KEY_DOWN, 1'b1, 1'b0);
    send_scan(8'h3A, 1'b0, 1'b0);
    send_scan(8'h7F, 1'b0, 1'b0);
  endtask

  initial begin
    sb = new();
    steady = 1'b0;
    rst <= 1'b1;
    scan_if.valid           <= 1'b0;
    scan_if.scan_code       <= '0;
    scan_if.switcher_active <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    for (int n = 0; n < RandomScans; n++) begin
      // a stretch with no idling on either side
      steady = (n >= 300 && n < 450);
      send_scan(pick_scan(), ($urandom_range(0, 4) == 0), (n == 600));
    end
    steady = 1'b0;
    scan_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[scancode_to_key_action_decoder_core] OK");
    end else begin
      $display("[scancode_to_key_action_decoder_core] ERROR");
    end
    $finish;
  end

  // output back-pressure
  initial begin
    int stall;
    result_if.ready <= 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid === 1'b1 && result_if.ready) begin
      sb.check_result(result_if.action, result_if.char_code);
    end
  end

  initial begin
    #(20_000_000);
    $display("[scancode_to_key_action_decoder_core] ERROR");
    $finish;
  end

endmodule
